FILE: sv/tcw_pkg.sv
// Package for the text console writer: shared constants, beat payload types and the
// command passed from the front end to the back end. No dependencies.
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] NULL_CODE = 8'd0;
  localparam logic [7:0] ATTR_RESET = 8'h0f;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } out_beat_t;

  typedef enum logic [1:0] {
    OP_IGNORE   = 2'd0,
    OP_PUT_CHAR = 2'd1,
    OP_NEWLINE  = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       in_range;
  } cmd_t;

endpackage

FILE: sv/tcw_front.sv
// Front end of the text console writer: accepts input beats and classifies them
// into commands for the queue. Depends on tcw_pkg.
module tcw_front #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::in_beat_t in_data,
  input  logic             q_full,
  input  logic             clearing,
  output logic             push,
  output tcw_pkg::cmd_t    cmd
);

  // Nothing is taken while the screen store is still being cleared after reset.
  assign in_stall = q_full | clearing;
  assign push = in_valid & ~in_stall;

  always_comb begin
    cmd.char_code = in_data.char_code;
    cmd.read_row = in_data.read_row;
    cmd.read_col = in_data.read_col;
    cmd.in_range = (int'(in_data.read_row) < ROWS) && (int'(in_data.read_col) < COLS);
    if (in_data.kind == tcw_pkg::KIND_READ) begin
      cmd.op = tcw_pkg::OP_READ;
    end else if (in_data.char_code == tcw_pkg::NULL_CODE) begin
      cmd.op = tcw_pkg::OP_IGNORE;
    end else if (in_data.char_code == tcw_pkg::NEWLINE_CODE) begin
      cmd.op = tcw_pkg::OP_NEWLINE;
    end else begin
      cmd.op = tcw_pkg::OP_PUT_CHAR;
    end
  end

endmodule

FILE: sv/tcw_fifo.sv
// Short command queue between the front and back ends of the text console writer.
// Depends on tcw_pkg.
module tcw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output tcw_pkg::cmd_t head_cmd
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/tcw_back.sv
// Back end of the text console writer: screen store, cursor, scrolling sequencer,
// attribute register and result register. Depends on tcw_pkg.
module tcw_back #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               q_not_empty,
  input  tcw_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_beat_t out_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLS);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_READ    = 7'b0000100,
    S_SCR_RD  = 7'b0001000,
    S_SCR_WR  = 7'b0010000,
    S_SCR_CLR = 7'b0100000,
    S_EXEC    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CUR_W-1:0]    cursor_r, cursor_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [CUR_W-1:0]    idx_r, idx_nxt;
  logic                scrolled_r, scrolled_nxt;
  tcw_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [7:0]          attr_r;
  logic                out_valid_r, out_valid_nxt;
  tcw_pkg::out_beat_t  out_r, out_nxt;
  logic                out_load;
  logic                out_free;

  logic [15:0]         mem [CELLS];
  logic [15:0]         rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [15:0]         mem_wdata;

  assign out_free = ~out_valid_r | ~out_stall;
  assign clearing = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    cursor_nxt = cursor_r;
    col_nxt = col_r;
    idx_nxt = idx_r;
    scrolled_nxt = scrolled_r;
    cmd_nxt = cmd_r;
    q_pop = 1'b0;
    out_load = 1'b0;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_waddr = ADDR_W'(idx_r);
    mem_wdata = '0;
    rd_addr = ADDR_W'(32'(q_cmd.read_row) * 32'(COLS) + 32'(q_cmd.read_col));

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CUR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // The result register is free at this edge, and only this item can fill it.
        if (q_not_empty && out_free) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          scrolled_nxt = 1'b0;
          idx_nxt = '0;
          case (q_cmd.op)
            tcw_pkg::OP_READ: state_nxt = S_READ;
            tcw_pkg::OP_IGNORE: begin
              out_load = 1'b1;
              out_nxt.cursor_cell = 11'(cursor_r);
              out_nxt.cell_char = '0;
              out_nxt.cell_attr = '0;
              out_nxt.scrolled = 1'b0;
            end
            default: begin
              state_nxt = (cursor_r >= CUR_W'(CELLS)) ? S_SCR_RD : S_EXEC;
            end
          endcase
        end
      end
      S_READ: begin
        out_load = 1'b1;
        out_nxt.cursor_cell = 11'(cursor_r);
        out_nxt.cell_char = cmd_r.in_range ? rd_data_r[7:0] : 8'd0;
        out_nxt.cell_attr = cmd_r.in_range ? rd_data_r[15:8] : 8'd0;
        out_nxt.scrolled = 1'b0;
        state_nxt = S_IDLE;
      end
      S_SCR_RD: begin
        rd_addr = ADDR_W'(idx_r + CUR_W'(COLS));
        state_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_we = 1'b1;
        mem_wdata = rd_data_r;
        idx_nxt = idx_r + 1'b1;
        state_nxt = (idx_r == CUR_W'(CELLS - COLS - 1)) ? S_SCR_CLR : S_SCR_RD;
      end
      S_SCR_CLR: begin
        mem_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CUR_W'(CELLS - 1)) begin
          cursor_nxt = cursor_r - CUR_W'(COLS);
          scrolled_nxt = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.op == tcw_pkg::OP_NEWLINE) begin
          cursor_nxt = cursor_r - CUR_W'(col_r) + CUR_W'(COLS);
          col_nxt = '0;
        end else begin
          mem_we = (cursor_r < CUR_W'(CELLS));
          mem_waddr = ADDR_W'(cursor_r);
          mem_wdata = {attr_r, cmd_r.char_code};
          cursor_nxt = cursor_r + 1'b1;
          col_nxt = (col_r == COL_W'(COLS - 1)) ? '0 : col_r + 1'b1;
        end
        out_load = 1'b1;
        out_nxt.cursor_cell = 11'(cursor_nxt);
        out_nxt.cell_char = '0;
        out_nxt.cell_attr = '0;
        out_nxt.scrolled = scrolled_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cursor_r <= '0;
      col_r <= '0;
      idx_r <= '0;
      scrolled_r <= 1'b0;
      attr_r <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cursor_r <= cursor_nxt;
      col_r <= col_nxt;
      idx_r <= idx_nxt;
      scrolled_r <= scrolled_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(CELLS))
    else $error("cursor beyond end of screen");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register loaded while a beat is still waiting");

  a_put_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r.op == tcw_pkg::OP_PUT_CHAR) |-> cursor_r < CUR_W'(CELLS))
    else $error("character put with the cursor outside the screen");

  a_scroll_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCR_CLR && idx_r == CUR_W'(CELLS - 1)) |=> (state_r == S_EXEC && scrolled_r))
    else $error("scroll did not hand over to the put step");

endmodule

FILE: sv/text_console_writer_core.sv
// Text console writer: put and read beats enter a front end, pass a two-entry queue
// and are carried out by the back end against the screen store. A put, newline or
// read gets its result from the S_EXEC or S_READ step, a null put straight from idle;
// a put or newline with the cursor past the end first scrolls the store by one row.
// The back end takes a new item only once it is through with the last one.
// Synchronous reset; afterwards a clearing pass over the whole store holds off input.
module text_console_writer_core #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_beat_t out_data
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  logic          clearing;
  tcw_pkg::cmd_t push_cmd;
  tcw_pkg::cmd_t head_cmd;

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  tcw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
